FILE: hw/rtl/best_fit_two_key_store_defines.svh
// Assertion macros shared by the best-fit two-key store RTL.
`ifndef BEST_FIT_TWO_KEY_STORE_DEFINES_SVH
`define BEST_FIT_TWO_KEY_STORE_DEFINES_SVH

`ifndef SYNTH
`define BFKS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BFKS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BFKS_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`define BFKS_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/bfks_pkg.sv
// Types, codes and default sizes of the best-fit two-key store.
package bfks_pkg;

    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 16;
    localparam int ID_WIDTH      = 32;
    localparam int FIELD_WIDTH   = 16;

    localparam logic [1:0] KIND_ADD       = 2'd0;
    localparam logic [1:0] KIND_BY_WEIGHT = 2'd1;
    localparam logic [1:0] KIND_BY_VOLUME = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NONE = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]             kind;
        logic [FIELD_WIDTH-1:0] weight;
        logic [FIELD_WIDTH-1:0] volume;
        logic [FIELD_WIDTH-1:0] threshold;
    } bfks_in_t;

    typedef struct packed {
        logic [1:0]          status;
        logic [ID_WIDTH-1:0] item_id;
    } bfks_out_t;

endpackage

FILE: hw/rtl/bfks_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
module bfks_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 65
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hw/rtl/bfks_engine.sv
// Scan engine: clears the table, scans it per beat and writes back the chosen entry.
`include "best_fit_two_key_store_defines.svh"

module bfks_engine #(
    parameter int CAPACITY  = bfks_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bfks_pkg::DEF_KEY_WIDTH,
    parameter int WORD_W    = 1 + 2 * KEY_WIDTH + bfks_pkg::ID_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bfks_pkg::bfks_in_t          req,
    output logic                        res_valid,
    input  logic                        res_ready,
    output bfks_pkg::bfks_out_t         res,
    output logic                        wr_en,
    output logic [$clog2(CAPACITY)-1:0] wr_addr,
    output logic [WORD_W-1:0]           wr_data,
    output logic                        rd_en,
    output logic [$clog2(CAPACITY)-1:0] rd_addr,
    input  logic [WORD_W-1:0]           rd_data
);

    import bfks_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_WIDTH;
    localparam logic [CW-1:0] CNT_END  = CW'(CAPACITY);
    localparam logic [CW-1:0] CNT_LAST = CW'(CAPACITY - 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(CAPACITY - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_RESPOND
    } state_t;

    state_t              state_reg,    state_next;
    logic [CW-1:0]       cnt_reg,      cnt_next;
    logic                pend_reg,     pend_next;
    logic [AW-1:0]       pend_idx_reg, pend_idx_next;
    logic [1:0]          kind_reg,     kind_next;
    logic [KW-1:0]       wkey_reg,     wkey_next;
    logic [KW-1:0]       vkey_reg,     vkey_next;
    logic [KW-1:0]       thr_reg,      thr_next;
    logic                found_reg,    found_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [KW-1:0]       best_key_reg, best_key_next;
    logic [ID_WIDTH-1:0] best_id_reg,  best_id_next;
    logic [ID_WIDTH-1:0] id_cnt_reg,   id_cnt_next;
    bfks_out_t           res_reg,      res_next;

    logic [31:0]         w_ext;
    logic [31:0]         v_ext;
    logic [31:0]         t_ext;
    logic                r_valid;
    logic [KW-1:0]       r_weight;
    logic [KW-1:0]       r_volume;
    logic [ID_WIDTH-1:0] r_id;
    logic [KW-1:0]       r_key;

    assign w_ext = {16'd0, req.weight};
    assign v_ext = {16'd0, req.volume};
    assign t_ext = {16'd0, req.threshold};

    assign r_valid  = rd_data[WORD_W-1];
    assign r_weight = rd_data[WORD_W-2 -: KW];
    assign r_volume = rd_data[WORD_W-2-KW -: KW];
    assign r_id     = rd_data[ID_WIDTH-1:0];
    assign r_key    = (kind_reg == KIND_BY_VOLUME) ? r_volume : r_weight;

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESPOND);
    assign res       = res_reg;

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pend_next     = 1'b0;
        pend_idx_next = cnt_reg[AW-1:0];
        kind_next     = kind_reg;
        wkey_next     = wkey_reg;
        vkey_next     = vkey_reg;
        thr_next      = thr_reg;
        found_next    = found_reg;
        best_idx_next = best_idx_reg;
        best_key_next = best_key_reg;
        best_id_next  = best_id_reg;
        id_cnt_next   = id_cnt_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = cnt_reg[AW-1:0];
        wr_data       = '0;
        rd_en         = 1'b0;
        rd_addr       = cnt_reg[AW-1:0];

        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    kind_next  = req.kind;
                    wkey_next  = w_ext[KW-1:0];
                    vkey_next  = v_ext[KW-1:0];
                    thr_next   = t_ext[KW-1:0];
                    found_next = 1'b0;
                    cnt_next   = '0;
                    case (req.kind) inside
                        KIND_ADD, KIND_BY_WEIGHT, KIND_BY_VOLUME:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            res_next   = '{status: ST_NONE, item_id: '0};
                            state_next = S_RESPOND;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (cnt_reg != CNT_END)
                begin
                    rd_en     = 1'b1;
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg + 1'b1;
                end
                if (pend_reg)
                begin
                    if (kind_reg == KIND_ADD)
                    begin
                        if (!r_valid && !found_reg)
                        begin
                            found_next    = 1'b1;
                            best_idx_next = pend_idx_reg;
                        end
                    end
                    else if (r_valid && (r_key >= thr_reg) &&
                             (!found_reg || (r_key < best_key_reg) ||
                              ((r_key == best_key_reg) && (r_id > best_id_reg))))
                    begin
                        found_next    = 1'b1;
                        best_idx_next = pend_idx_reg;
                        best_key_next = r_key;
                        best_id_next  = r_id;
                    end
                    if (pend_idx_reg == IDX_LAST)
                    begin
                        state_next = S_COMMIT;
                    end
                end
            end

            S_COMMIT:
            begin
                wr_addr    = best_idx_reg;
                state_next = S_RESPOND;
                if (kind_reg == KIND_ADD)
                begin
                    if (found_reg && (id_cnt_reg != {ID_WIDTH{1'b1}}))
                    begin
                        wr_en       = 1'b1;
                        wr_data     = {1'b1, wkey_reg, vkey_reg, id_cnt_reg};
                        res_next    = '{status: ST_OK, item_id: id_cnt_reg};
                        id_cnt_next = id_cnt_reg + 1'b1;
                    end
                    else
                    begin
                        res_next = '{status: ST_FULL, item_id: '0};
                    end
                end
                else if (found_reg)
                begin
                    wr_en    = 1'b1;
                    res_next = '{status: ST_OK, item_id: best_id_reg};
                end
                else
                begin
                    res_next = '{status: ST_NONE, item_id: '0};
                end
            end

            S_RESPOND:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            pend_idx_reg <= '0;
            kind_reg     <= KIND_ADD;
            wkey_reg     <= '0;
            vkey_reg     <= '0;
            thr_reg      <= '0;
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
            best_key_reg <= '0;
            best_id_reg  <= '0;
            id_cnt_reg   <= '0;
            res_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            pend_idx_reg <= pend_idx_next;
            kind_reg     <= kind_next;
            wkey_reg     <= wkey_next;
            vkey_reg     <= vkey_next;
            thr_reg      <= thr_next;
            found_reg    <= found_next;
            best_idx_reg <= best_idx_next;
            best_key_reg <= best_key_next;
            best_id_reg  <= best_id_next;
            id_cnt_reg   <= id_cnt_next;
            res_reg      <= res_next;
        end
    end

    `BFKS_ASSERT_IMP(a_no_write_in_scan, clk, rst_n, state_reg == S_SCAN, !wr_en, "table written during a scan")
    `BFKS_ASSERT_IMP(a_id_step_on_commit, clk, rst_n, id_cnt_reg != $past(id_cnt_reg), ($past(state_reg) == S_COMMIT) && (id_cnt_reg == $past(id_cnt_reg) + 1'b1), "id counter moved outside an add commit")
    `BFKS_ASSERT_NXT(a_scan_ends_in_commit, clk, rst_n, (state_reg == S_SCAN) && pend_reg && (pend_idx_reg == IDX_LAST), state_reg == S_COMMIT, "scan did not end in a commit")

endmodule

FILE: hw/rtl/best_fit_two_key_store.sv
// Best-fit two-key store: a table of items taken out by smallest fitting weight or volume.
//
// Request channel (req_valid, req_ready, req): one beat per operation. kind selects an add
// of (weight, volume), a best-fit take by weight or one by volume against threshold.
// Response channel (rsp_valid, rsp_ready, rsp): exactly one beat per request, in order,
// with status and item_id; item_id is zero whenever status is not ok.
// Each add or take reads every table entry once through the one read port of the table RAM,
// then writes back the new or removed entry, if there is one. A new request is accepted only
// after the previous response has left the engine. An unknown kind skips the scan and is
// answered with status none.
// The response sits in an output register, so a stalled receiver does not block the next
// request; the engine holds a finished result until that register frees up.
// After reset the table RAM is cleared one entry per cycle, every entry in turn, with req_ready
// low; the id counter starts at zero.
module best_fit_two_key_store #(
    parameter int CAPACITY  = bfks_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = bfks_pkg::DEF_KEY_WIDTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  bfks_pkg::bfks_in_t  req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output bfks_pkg::bfks_out_t rsp
);

    import bfks_pkg::*;

    localparam int AW     = $clog2(CAPACITY);
    localparam int WORD_W = 1 + 2 * KEY_WIDTH + ID_WIDTH;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              eng_valid;
    logic              eng_ready;
    bfks_out_t         eng_res;
    logic              rsp_valid_reg;
    bfks_out_t         rsp_reg;

    bfks_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (WORD_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bfks_engine #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH),
        .WORD_W    (WORD_W)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (eng_valid),
        .res_ready (eng_ready),
        .res       (eng_res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data)
    );

    assign eng_ready = !rsp_valid_reg || rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (eng_valid && eng_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_valid && eng_ready)
        begin
            rsp_reg <= eng_res;
        end
    end

    `BFKS_ASSERT_IMP(a_zero_id_on_error, clk, rst_n, rsp_valid && (rsp.status != ST_OK), rsp.item_id == '0, "error response carries a nonzero id")
    `BFKS_ASSERT_NXT(a_engine_holds_result, clk, rst_n, eng_valid && !eng_ready, eng_valid && (eng_res == $past(eng_res)), "engine dropped a stalled result")

endmodule
